// ----- rtl/core/wgod_pkg.sv -----
`timescale 1ns / 1ps

package wgod_pkg;

   // Operation codes sent from the controller to the datapath.
   localparam logic [3:0] OP_IDLE     = 4'd0;
   localparam logic [3:0] OP_LOAD     = 4'd1;
   localparam logic [3:0] OP_MEAN     = 4'd2;
   localparam logic [3:0] OP_MUL_A    = 4'd3;
   localparam logic [3:0] OP_MUL_B    = 4'd4;
   localparam logic [3:0] OP_MUL_C    = 4'd5;
   localparam logic [3:0] OP_VDIV     = 4'd6;
   localparam logic [3:0] OP_SQRT     = 4'd7;
   localparam logic [3:0] OP_BAND     = 4'd8;
   localparam logic [3:0] OP_DECIDE   = 4'd9;
   localparam logic [3:0] OP_ACC_WX   = 4'd10;
   localparam logic [3:0] OP_ACC_SQ   = 4'd11;
   localparam logic [3:0] OP_ACC_TERM = 4'd12;
   localparam logic [3:0] OP_ACC_UPD  = 4'd13;
   localparam logic [3:0] OP_PUBLISH  = 4'd14;

   // Configuration register indexes.
   localparam logic [1:0] REG_TRAIN_SPAN  = 2'd0;
   localparam logic [1:0] REG_DEV_MULT    = 2'd1;
   localparam logic [1:0] REG_WEIGHT_STEP = 2'd2;

   // Divider geometry: left-aligned numerator, iteration count per division.
   localparam int DIV_NUM_W = 128;
   localparam int DIV_DEN_W = 96;
   localparam int DIV_QUO_W = 64;
   localparam int DIV_CNT_W = 8;
   localparam logic [DIV_CNT_W-1:0] MEAN_ITERS = 8'd72;
   localparam logic [DIV_CNT_W-1:0] VAR_ITERS  = 8'd128;

   localparam logic [23:0] WEIGHT_ONE = 24'd256;
   localparam logic [63:0] MEAN_LIMIT = 64'h4000_0000_0000_0000;

   typedef struct packed {
      logic [3:0] op;
      logic       start;
   } wgod_cmd_type;

   typedef struct packed {
      logic done;
      logic train;
      logic zden;
      logic neg;
      logic outlier;
   } wgod_sts_type;

endpackage

// ----- rtl/core/wgod_mul.sv -----
`timescale 1ns / 1ps

// Unsigned 64 x 64 multiplier built from four 32 x 32 partial products.
module wgod_mul (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  a,
   input  logic [63:0]  b,
   output logic         done,
   output logic [127:0] prod
);

   logic [63:0]  a_ff, b_ff;
   logic [127:0] acc_ff, acc_in;
   logic [1:0]   step_ff;
   logic         busy_ff, done_ff;
   logic [31:0]  a_half, b_half;
   logic [63:0]  pp;
   logic [127:0] pp_sh;

   // Select the halves for this step and place the partial product.
   always_comb begin
      a_half = step_ff[1] ? a_ff[63:32] : a_ff[31:0];
      b_half = step_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp     = a_half * b_half;
      unique case ({step_ff[1], step_ff[0]})
         2'b00:   pp_sh = {64'd0, pp};
         2'b11:   pp_sh = {pp, 64'd0};
         default: pp_sh = {32'd0, pp, 32'd0};
      endcase
      acc_in = acc_ff + pp_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= 2'd0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Operands and accumulator.
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// ----- rtl/core/wgod_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The numerator arrives
// left-aligned; quotient bits that fall off the top set the overflow flag.
module wgod_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [wgod_pkg::DIV_NUM_W-1:0]        num,
   input  logic [wgod_pkg::DIV_DEN_W-1:0]        den,
   input  logic [wgod_pkg::DIV_CNT_W-1:0]        iters,
   output logic                                  done,
   output logic [wgod_pkg::DIV_QUO_W-1:0]        quo,
   output logic                                  ovf
);

   localparam logic [wgod_pkg::DIV_CNT_W-1:0] CNT_ONE =
      {{(wgod_pkg::DIV_CNT_W-1){1'b0}}, 1'b1};

   logic [wgod_pkg::DIV_NUM_W-1:0] n_ff;
   logic [wgod_pkg::DIV_DEN_W-1:0] d_ff, rem_ff, rem_in;
   logic [wgod_pkg::DIV_QUO_W-1:0] q_ff;
   logic [wgod_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                           ovf_ff, busy_ff, done_ff;
   logic [wgod_pkg::DIV_DEN_W:0]   rem2, diff;
   logic                           ge;

   // One trial subtraction.
   always_comb begin
      rem2   = {rem_ff, n_ff[wgod_pkg::DIV_NUM_W-1]};
      diff   = rem2 - {1'b0, d_ff};
      ge     = rem2 >= {1'b0, d_ff};
      rem_in = ge ? diff[wgod_pkg::DIV_DEN_W-1:0] : rem2[wgod_pkg::DIV_DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= iters;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_ONE;
            if (cnt_ff == CNT_ONE) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         n_ff   <= num;
         d_ff   <= den;
         rem_ff <= '0;
         q_ff   <= '0;
         ovf_ff <= 1'b0;
      end else if (busy_ff) begin
         n_ff   <= n_ff << 1;
         rem_ff <= rem_in;
         q_ff   <= {q_ff[wgod_pkg::DIV_QUO_W-2:0], ge};
         ovf_ff <= ovf_ff | q_ff[wgod_pkg::DIV_QUO_W-1];
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;
   assign ovf  = ovf_ff;

`ifndef SYNTHESIS
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider started while busy");
   a_done_follows: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == CNT_ONE) |=> done_ff)
      else $error("divider missed its done pulse");
`endif

endmodule

// ----- rtl/core/wgod_dp.sv -----
`timescale 1ns / 1ps

// Datapath: running sums, configuration, shared multiplier and divider,
// square-root iteration and the band test.
module wgod_dp #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  wgod_pkg::wgod_cmd_type      cmd,
   output wgod_pkg::wgod_sts_type      sts,
   input  logic [SAMPLE_BITS-1:0]      req_sample,
   input  logic                        csr_wr_en,
   input  logic [1:0]                  csr_index,
   input  logic [15:0]                 csr_wdata,
   output logic                        rsp_is_outlier,
   output logic                        rsp_in_training
);

   localparam int XQ_W = 66;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_ONE = {{(SAMPLE_BITS-1){1'b0}}, 1'b1};

   // Configuration.
   logic [15:0] tw_ff, ws_ff;
   logic [7:0]  dm_ff;

   // Running state.
   logic [47:0] s0_ff, s0_in;
   logic [63:0] s1_ff, s1_in, s2_ff, s2_in;
   logic [23:0] w_ff, w_in;
   logic [15:0] cnt_ff;

   // Per-request working registers.
   logic [SAMPLE_BITS-1:0] x_ff, mag_ff, mag_in;
   logic        train_ff, zden_ff, neg_ff, outlier_ff;
   logic [111:0] p1_ff, num_ff;
   logic [95:0] den_ff;
   logic [63:0] mean_ff, var_ff, term_ff;
   logic [47:0] tmag_ff, sq_ff;
   logic [39:0] band_ff;
   logic        out_outlier_ff, out_train_ff;

   // Square-root iteration.
   logic [63:0] rad_ff;
   logic [31:0] root_ff;
   logic [33:0] srem_ff;
   logic [5:0]  scnt_ff;
   logic        sbusy_ff, sdone_ff;
   logic [35:0] srem2, strial;
   logic        sge;

   // Shared units.
   logic         mul_start, div_start, mul_done, div_done, div_ovf;
   logic [63:0]  mul_a, mul_b, div_quo, s1mag, mean_mag;
   logic [127:0] mul_prod;
   logic [wgod_pkg::DIV_NUM_W-1:0] div_num;
   logic [wgod_pkg::DIV_DEN_W-1:0] div_den;
   logic [wgod_pkg::DIV_CNT_W-1:0] div_iters;

   // Band test and accumulation arithmetic.
   logic signed [XQ_W-1:0] xq, mean_x, lo, hi;
   logic        outlier_c;
   logic [48:0] s0_sum;
   logic [64:0] t65, s1_sum, s2_sum;
   logic [24:0] w_sum;
   logic        start_on;

   assign s1mag    = s1_ff[63] ? (~s1_ff + 64'd1) : s1_ff;
   assign mag_in   = req_sample[SAMPLE_BITS-1] ? (~req_sample + SAMPLE_ONE) : req_sample;
   assign mean_mag = (div_ovf || div_quo > wgod_pkg::MEAN_LIMIT) ? wgod_pkg::MEAN_LIMIT
                                                                 : div_quo;
   assign start_on = cmd.start;

   // Operand selection for the shared multiplier and divider.
   always_comb begin
      mul_start = 1'b0;
      div_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      div_num   = '0;
      div_den   = '0;
      div_iters = wgod_pkg::VAR_ITERS;
      unique case (cmd.op)
         wgod_pkg::OP_MEAN: begin
            div_start = start_on;
            div_num   = {s1mag, 8'd0, 56'd0};
            div_den   = {48'd0, s0_ff};
            div_iters = wgod_pkg::MEAN_ITERS;
         end
         wgod_pkg::OP_VDIV: begin
            div_start = start_on;
            div_num   = {num_ff, 16'd0};
            div_den   = den_ff;
         end
         wgod_pkg::OP_MUL_A: begin
            mul_start = start_on;
            mul_a     = {16'd0, s0_ff};
            mul_b     = s2_ff;
         end
         wgod_pkg::OP_MUL_B: begin
            mul_start = start_on;
            mul_a     = s1mag;
            mul_b     = s1mag;
         end
         wgod_pkg::OP_MUL_C: begin
            mul_start = start_on;
            mul_a     = {16'd0, s0_ff};
            mul_b     = {16'd0, s0_ff - {24'd0, wgod_pkg::WEIGHT_ONE}};
         end
         wgod_pkg::OP_ACC_WX: begin
            mul_start = start_on;
            mul_a     = {40'd0, w_ff};
            mul_b     = {{(64-SAMPLE_BITS){1'b0}}, mag_ff};
         end
         wgod_pkg::OP_ACC_SQ: begin
            mul_start = start_on;
            mul_a     = {{(64-SAMPLE_BITS){1'b0}}, mag_ff};
            mul_b     = {{(64-SAMPLE_BITS){1'b0}}, mag_ff};
         end
         wgod_pkg::OP_ACC_TERM: begin
            mul_start = start_on;
            mul_a     = {16'd0, sq_ff};
            mul_b     = {40'd0, w_ff};
         end
         default: begin
         end
      endcase
   end

   wgod_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   wgod_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .iters (div_iters),
      .done  (div_done),
      .quo   (div_quo),
      .ovf   (div_ovf)
   );

   // Band comparison against the sample scaled to Q.8.
   always_comb begin
      xq        = {{(XQ_W-SAMPLE_BITS-8){x_ff[SAMPLE_BITS-1]}}, x_ff, 8'd0};
      mean_x    = {{(XQ_W-64){mean_ff[63]}}, mean_ff};
      lo        = mean_x - $signed({{(XQ_W-40){1'b0}}, band_ff});
      hi        = mean_x + $signed({{(XQ_W-40){1'b0}}, band_ff});
      outlier_c = (xq < lo) || (xq > hi);
   end

   // Saturating updates of the running sums.
   always_comb begin
      s0_sum = {1'b0, s0_ff} + {25'd0, w_ff};
      s0_in  = s0_sum[48] ? '1 : s0_sum[47:0];
      t65    = x_ff[SAMPLE_BITS-1] ? (65'd0 - {17'd0, tmag_ff}) : {17'd0, tmag_ff};
      s1_sum = {s1_ff[63], s1_ff} + t65;
      if (s1_sum[64] != s1_sum[63]) begin
         s1_in = s1_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         s1_in = s1_sum[63:0];
      end
      s2_sum = {1'b0, s2_ff} + {1'b0, term_ff};
      s2_in  = s2_sum[64] ? '1 : s2_sum[63:0];
      w_sum  = {1'b0, w_ff} + {9'd0, ws_ff};
      w_in   = w_sum[24] ? '1 : w_sum[23:0];
   end

   // Square-root trial step.
   always_comb begin
      srem2  = {srem_ff, rad_ff[63:62]};
      strial = {2'd0, root_ff, 2'b01};
      sge    = srem2 >= strial;
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         tw_ff <= 16'd1;
         dm_ff <= 8'd3;
         ws_ff <= 16'd0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            wgod_pkg::REG_TRAIN_SPAN:  tw_ff <= csr_wdata;
            wgod_pkg::REG_DEV_MULT:    dm_ff <= csr_wdata[7:0];
            wgod_pkg::REG_WEIGHT_STEP: ws_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Running state: reset to zero sums with the weight at WEIGHT_ONE, updated once per accumulated sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff  <= '0;
         s1_ff  <= '0;
         s2_ff  <= '0;
         w_ff   <= wgod_pkg::WEIGHT_ONE;
         cnt_ff <= '0;
      end else if (cmd.start && cmd.op == wgod_pkg::OP_ACC_UPD) begin
         s0_ff  <= s0_in;
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         w_ff   <= w_in;
         cnt_ff <= (cnt_ff == 16'hFFFF) ? cnt_ff : cnt_ff + 16'd1;
      end
   end

   // Square-root sequencing.
   always_ff @(posedge clock) begin
      if (reset) begin
         sbusy_ff <= 1'b0;
         sdone_ff <= 1'b0;
         scnt_ff  <= '0;
      end else begin
         sdone_ff <= 1'b0;
         if (cmd.start && cmd.op == wgod_pkg::OP_SQRT) begin
            sbusy_ff <= 1'b1;
            scnt_ff  <= '0;
         end else if (sbusy_ff) begin
            scnt_ff <= scnt_ff + 6'd1;
            if (scnt_ff == 6'd31) begin
               sbusy_ff <= 1'b0;
               sdone_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start && cmd.op == wgod_pkg::OP_SQRT) begin
         rad_ff  <= var_ff;
         root_ff <= '0;
         srem_ff <= '0;
      end else if (sbusy_ff) begin
         rad_ff  <= rad_ff << 2;
         root_ff <= {root_ff[30:0], sge};
         srem_ff <= sge ? (srem2[33:0] - strial[33:0]) : srem2[33:0];
      end
   end

   // Per-request control flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         train_ff       <= 1'b0;
         zden_ff        <= 1'b0;
         neg_ff         <= 1'b0;
         outlier_ff     <= 1'b0;
         out_outlier_ff <= 1'b0;
         out_train_ff   <= 1'b0;
      end else begin
         if (cmd.start && cmd.op == wgod_pkg::OP_LOAD) begin
            train_ff   <= cnt_ff < tw_ff;
            zden_ff    <= s0_ff <= {24'd0, wgod_pkg::WEIGHT_ONE};
            neg_ff     <= 1'b0;
            outlier_ff <= 1'b0;
         end
         if (mul_done && cmd.op == wgod_pkg::OP_MUL_B) begin
            neg_ff <= mul_prod > {16'd0, p1_ff};
         end
         if (cmd.start && cmd.op == wgod_pkg::OP_DECIDE) begin
            outlier_ff <= outlier_c;
         end
         if (cmd.start && cmd.op == wgod_pkg::OP_PUBLISH) begin
            out_outlier_ff <= outlier_ff;
            out_train_ff   <= train_ff;
         end
      end
   end

   // Per-request payload registers.
   always_ff @(posedge clock) begin
      if (cmd.start && cmd.op == wgod_pkg::OP_LOAD) begin
         x_ff   <= req_sample;
         mag_ff <= mag_in;
      end
      if (div_done && cmd.op == wgod_pkg::OP_MEAN) begin
         mean_ff <= s1_ff[63] ? (64'd0 - mean_mag) : mean_mag;
      end
      if (div_done && cmd.op == wgod_pkg::OP_VDIV) begin
         var_ff <= div_ovf ? '1 : div_quo;
      end
      if (mul_done) begin
         unique case (cmd.op)
            wgod_pkg::OP_MUL_A: p1_ff <= mul_prod[111:0];
            wgod_pkg::OP_MUL_B: begin
               num_ff <= p1_ff - mul_prod[111:0];
               if (mul_prod > {16'd0, p1_ff}) begin
                  var_ff <= '0;
               end
            end
            wgod_pkg::OP_MUL_C:    den_ff  <= mul_prod[95:0];
            wgod_pkg::OP_ACC_WX:   tmag_ff <= mul_prod[47:0];
            wgod_pkg::OP_ACC_SQ:   sq_ff   <= mul_prod[47:0];
            wgod_pkg::OP_ACC_TERM: term_ff <= (|mul_prod[127:64]) ? '1 : mul_prod[63:0];
            default: begin
            end
         endcase
      end
      if (cmd.start && cmd.op == wgod_pkg::OP_BAND) begin
         band_ff <= {8'd0, root_ff} * {32'd0, dm_ff};
      end
   end

   assign sts.done    = mul_done | div_done | sdone_ff;
   assign sts.train   = train_ff;
   assign sts.zden    = zden_ff;
   assign sts.neg     = neg_ff;
   assign sts.outlier = outlier_c;

   assign rsp_is_outlier  = out_outlier_ff;
   assign rsp_in_training = out_train_ff;

endmodule

// ----- rtl/core/wgod_ctrl.sv -----
`timescale 1ns / 1ps

// Controller: walks one request through the test and accumulation steps.
module wgod_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output wgod_pkg::wgod_cmd_type  cmd,
   input  wgod_pkg::wgod_sts_type  sts
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_CLASS    = 4'd1;
   localparam logic [3:0] ST_MEAN     = 4'd2;
   localparam logic [3:0] ST_MUL_A    = 4'd3;
   localparam logic [3:0] ST_MUL_B    = 4'd4;
   localparam logic [3:0] ST_MUL_C    = 4'd5;
   localparam logic [3:0] ST_VDIV     = 4'd6;
   localparam logic [3:0] ST_SQRT     = 4'd7;
   localparam logic [3:0] ST_BAND     = 4'd8;
   localparam logic [3:0] ST_DECIDE   = 4'd9;
   localparam logic [3:0] ST_ACC_WX   = 4'd10;
   localparam logic [3:0] ST_ACC_SQ   = 4'd11;
   localparam logic [3:0] ST_ACC_TERM = 4'd12;
   localparam logic [3:0] ST_ACC_UPD  = 4'd13;
   localparam logic [3:0] ST_DONE     = 4'd14;

   logic [3:0] state_ff, state_in;
   logic       issued_ff, issued_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state and command for the datapath.
   always_comb begin
      state_in  = state_ff;
      issued_in = issued_ff;
      cmd.op    = wgod_pkg::OP_IDLE;
      cmd.start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.op    = wgod_pkg::OP_LOAD;
            cmd.start = req_tvalid;
            if (req_tvalid) state_in = ST_CLASS;
         end
         ST_CLASS: begin
            state_in = (sts.train || sts.zden) ? ST_ACC_WX : ST_MEAN;
         end
         ST_MEAN, ST_MUL_A, ST_MUL_B, ST_MUL_C, ST_VDIV, ST_SQRT,
         ST_ACC_WX, ST_ACC_SQ, ST_ACC_TERM: begin
            unique case (state_ff)
               ST_MEAN:   cmd.op = wgod_pkg::OP_MEAN;
               ST_MUL_A:  cmd.op = wgod_pkg::OP_MUL_A;
               ST_MUL_B:  cmd.op = wgod_pkg::OP_MUL_B;
               ST_MUL_C:  cmd.op = wgod_pkg::OP_MUL_C;
               ST_VDIV:   cmd.op = wgod_pkg::OP_VDIV;
               ST_SQRT:   cmd.op = wgod_pkg::OP_SQRT;
               ST_ACC_WX: cmd.op = wgod_pkg::OP_ACC_WX;
               ST_ACC_SQ: cmd.op = wgod_pkg::OP_ACC_SQ;
               default:   cmd.op = wgod_pkg::OP_ACC_TERM;
            endcase
            cmd.start = !issued_ff;
            if (!issued_ff) issued_in = 1'b1;
            if (issued_ff && sts.done) begin
               issued_in = 1'b0;
               unique case (state_ff)
                  ST_MEAN:   state_in = ST_MUL_A;
                  ST_MUL_A:  state_in = ST_MUL_B;
                  ST_MUL_B:  state_in = ST_MUL_C;
                  ST_MUL_C:  state_in = sts.neg ? ST_SQRT : ST_VDIV;
                  ST_VDIV:   state_in = ST_SQRT;
                  ST_SQRT:   state_in = ST_BAND;
                  ST_ACC_WX: state_in = ST_ACC_SQ;
                  ST_ACC_SQ: state_in = ST_ACC_TERM;
                  default:   state_in = ST_ACC_UPD;
               endcase
            end
         end
         ST_BAND: begin
            cmd.op    = wgod_pkg::OP_BAND;
            cmd.start = 1'b1;
            state_in  = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.op    = wgod_pkg::OP_DECIDE;
            cmd.start = 1'b1;
            state_in  = sts.outlier ? ST_DONE : ST_ACC_WX;
         end
         ST_ACC_UPD: begin
            cmd.op    = wgod_pkg::OP_ACC_UPD;
            cmd.start = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            cmd.op    = wgod_pkg::OP_PUBLISH;
            cmd.start = out_free;
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in  = ST_IDLE;
            issued_in = 1'b0;
         end
      endcase
   end

   // Result valid: set on publish, cleared when the result is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_class: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_tvalid) |=> state_ff == ST_CLASS)
      else $error("accepted request did not enter classification");
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.start && cmd.op == wgod_pkg::OP_PUBLISH) |-> out_free)
      else $error("result published over a pending result");
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      sts.done |-> (state_ff == ST_MEAN || state_ff == ST_MUL_A ||
                    state_ff == ST_MUL_B || state_ff == ST_MUL_C ||
                    state_ff == ST_VDIV || state_ff == ST_SQRT ||
                    state_ff == ST_ACC_WX || state_ff == ST_ACC_SQ ||
                    state_ff == ST_ACC_TERM))
      else $error("unit done outside a waiting state");
   a_done_issued: assert property (@(posedge clock) disable iff (reset)
      sts.done |-> issued_ff) else $error("unit done without a start");
`endif

endmodule

// ----- rtl/core/weighted_gaussian_outlier_detector.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Ports                          Contents
// req       in         req_tvalid/tready/tdata        sample
// rsp       out        rsp_tvalid/tready/tdata/tuser  is_outlier; tuser: in_training
// csr       in         csr_wr_en/index/wdata          training span, multiplier, step
//
// A training request, or one taken while the weight sum is at most 1.0, holds
// the block for three passes through the shared multiplier. A tested request
// also runs the bit-serial divider (72 steps for the mean, 128 for the
// variance) and the 32-step square root, and skips the accumulation passes
// when flagged; a negative variance skips the variance division.
// One request is in work at a time; a finished result waits in the output
// register while the next request is taken. Reset is synchronous.
module weighted_gaussian_outlier_detector #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      req_tdata,  // sample
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [7:0]                            rsp_tdata,  // is_outlier
   output logic                                  rsp_tuser,  // in_training
   input  logic                                  csr_wr_en,
   input  logic [1:0]                            csr_index,
   input  logic [15:0]                           csr_wdata
);

   wgod_pkg::wgod_cmd_type cmd;
   wgod_pkg::wgod_sts_type sts;
   logic                   is_outlier, in_training;

   wgod_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   wgod_dp #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_sample      (req_tdata[SAMPLE_BITS-1:0]),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_is_outlier  (is_outlier),
      .rsp_in_training (in_training)
   );

   assign rsp_tdata = {7'd0, is_outlier};
   assign rsp_tuser = in_training;

endmodule

// ----- tb/weighted_gaussian_outlier_detector_test.sv -----
`timescale 1ns / 1ps

module weighted_gaussian_outlier_detector_test;

   // Index that maps to no register; writes to it must be ignored.
   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int         TAIL_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // sample
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // is_outlier
   logic        rsp_tuser;        // in_training
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   weighted_gaussian_outlier_detector dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow copy of the detector's registers and running sums.
   logic [15:0]        window_cfg = 16'd1;
   logic [7:0]         multiplier_cfg = 8'd3;
   logic [15:0]        step_cfg = 16'd0;
   logic [47:0]        weight_total = '0;
   logic signed [63:0] value_total = '0;
   logic [63:0]        square_total = '0;
   logic [23:0]        weight_now = 24'd256;
   logic [15:0]        taken_count = '0;

   // Each entry holds {in_training, is_outlier}.
   logic [1:0] pending_flags[$];
   int         mismatches = 0;
   int         requests_sent = 0;
   int         responses_seen = 0;
   int         outliers_seen = 0;
   bit         calm = 1'b0;
   int         stall_left = 0;

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = '0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Fold one sample into the weighted sums, all with saturation.
   function automatic void fold_sample(longint x);
      logic [63:0]        w;
      longint             t;
      logic [63:0]        mag;
      logic [127:0]       term;
      logic [48:0]        ws;
      logic signed [64:0] vs;
      logic [128:0]       ss;
      logic [24:0]        nw;
      w = {40'b0, weight_now};
      t = longint'(w) * x;
      mag = (x < 0) ? 64'(-x) : 64'(x);
      term = mag * mag * w;
      ws = weight_total + w;
      weight_total = ws[48] ? 48'hFFFF_FFFF_FFFF : ws[47:0];
      vs = 65'(value_total) + 65'(t);
      if (vs[64] != vs[63]) begin
         value_total = vs[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      end else begin
         value_total = vs[63:0];
      end
      if (term > 128'hFFFF_FFFF_FFFF_FFFF) term = 128'hFFFF_FFFF_FFFF_FFFF;
      ss = square_total + term;
      square_total = (ss > 129'hFFFF_FFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : ss[63:0];
      nw = weight_now + step_cfg;
      weight_now = nw[24] ? 24'hFF_FFFF : nw[23:0];
      if (taken_count != 16'hFFFF) taken_count = taken_count + 1'b1;
   endfunction

   // Band test around the weighted mean; a zero denominator means no outlier.
   function automatic bit beyond_band(longint x);
      logic [63:0]  s1mag;
      logic [127:0] q;
      logic [127:0] num;
      logic [127:0] sq1;
      logic [127:0] den;
      logic [143:0] vq;
      logic [63:0]  variance;
      longint       mean;
      longint       band;
      longint       xq;
      if (weight_total <= 48'd256) return 1'b0;
      s1mag = (value_total < 0) ? 64'(-value_total) : 64'(value_total);
      q = ({64'b0, s1mag} << 8) / weight_total;
      if (q > 128'(wgod_pkg::MEAN_LIMIT)) q = 128'(wgod_pkg::MEAN_LIMIT);
      mean = (value_total < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
      num = weight_total * square_total;
      sq1 = s1mag * s1mag;
      if (sq1 > num) begin
         variance = '0;
      end else begin
         den = weight_total * (weight_total - 48'd256);
         vq = {num - sq1, 16'b0} / den;
         variance = (vq >= (144'd1 << 64)) ? 64'hFFFF_FFFF_FFFF_FFFF : vq[63:0];
      end
      band = longint'(int_sqrt(variance) * multiplier_cfg);
      xq = x * 256;
      return (xq < mean - band) || (xq > mean + band);
   endfunction

   function automatic logic [1:0] classify_sample(logic [15:0] raw);
      longint x;
      x = longint'($signed(raw));
      if (taken_count < window_cfg) begin
         fold_sample(x);
         return 2'b10;
      end
      if (beyond_band(x)) return 2'b01;
      fold_sample(x);
      return 2'b00;
   endfunction

   // Send one request and record its expected flags once it is taken.
   task automatic send_sample(logic [15:0] value);
      req_tvalid <= 1'b1;
      req_tdata <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_flags.push_back(classify_sample(value));
      requests_sent++;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic write_register(logic [1:0] index, logic [15:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (index)
         wgod_pkg::REG_TRAIN_SPAN:  window_cfg = value;
         wgod_pkg::REG_DEV_MULT:    multiplier_cfg = value[7:0];
         wgod_pkg::REG_WEIGHT_STEP: step_cfg = value;
         default: ;
      endcase
   endtask

   // Wait until every response is in and the block has gone quiet.
   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_flags.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // Mostly samples around a centre, now and then a spike anywhere in range.
   function automatic logic [15:0] pick_sample(int centre, int spread);
      int v;
      if ($urandom_range(0, 4) == 0) return 16'($urandom);
      v = centre + int'($urandom_range(0, 2 * spread)) - spread;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
   endfunction

   // Response side: random stall bursts, none once the run is calm.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 16);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare every response with the oldest expectation.
   always @(posedge clock) begin
      logic [1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses_seen++;
         if (rsp_tdata[0]) outliers_seen++;
         if (pending_flags.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %b", {rsp_tuser, rsp_tdata[0]});
         end else begin
            want = pending_flags.pop_front();
            if (rsp_tdata[0] !== want[0] || rsp_tuser !== want[1]) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("response %0d: is_outlier exp %b got %b, in_training exp %b got %b",
                           responses_seen, want[0], rsp_tdata[0], want[1], rsp_tuser);
               end
            end
         end
      end
   end

   task automatic test_window_zero;
      write_register(wgod_pkg::REG_TRAIN_SPAN, 16'd0);
      send_sample(16'd100);
      send_sample(16'd100);
      send_sample(16'd120);
      send_sample(16'd90);
      drain();
   endtask

   task automatic test_extremes;
      write_register(wgod_pkg::REG_DEV_MULT, 16'd255);
      write_register(wgod_pkg::REG_WEIGHT_STEP, 16'hFFFF);
      write_register(wgod_pkg::REG_TRAIN_SPAN, 16'd8);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      send_sample(16'h0000);
      send_sample(16'hFFFF);
      send_sample(16'h0001);
      send_sample(16'h8000);
      drain();
      write_register(wgod_pkg::REG_DEV_MULT, 16'd0);
      send_sample(16'h7FFF);
      send_sample(16'h0000);
      send_sample(16'h5555);
      send_sample(16'hAAAA);
      drain();
   endtask

   task automatic test_unused_index;
      write_register(REG_UNUSED, 16'hFFFF);
      write_register(wgod_pkg::REG_DEV_MULT, 16'd3);
      send_sample(16'd5);
      send_sample(16'h8000);
      send_sample(16'd7);
      drain();
   endtask

   task automatic test_random_phase(logic [15:0] window, logic [7:0] mult, logic [15:0] step,
                                    int count, int centre, int spread);
      write_register(wgod_pkg::REG_TRAIN_SPAN, window);
      write_register(wgod_pkg::REG_DEV_MULT, {8'd0, mult});
      write_register(wgod_pkg::REG_WEIGHT_STEP, step);
      repeat (count) send_sample(pick_sample(centre, spread));
      drain();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_window_zero();
      test_extremes();
      test_unused_index();
      test_random_phase(16'd20, 8'd3, 16'd0, 200, 1000, 300);
      test_random_phase(16'hFFFF, 8'd255, 16'hFFFF, 100, 0, 32767);
      test_random_phase(16'd1, 8'd0, 16'd1, 150, -5000, 2000);
      test_random_phase(16'd1, 8'd1, 16'($urandom), 200, 2000, 4000);
      test_random_phase(16'd1, 8'd2, 16'd0, 200, int'($urandom_range(0, 40000)) - 20000, 800);
      calm = 1'b1;
      test_random_phase(16'd1, 8'd3, 16'd300, 280, 300, 1500);
      $display("run covered %0d requests and %0d responses, %0d of them outliers",
               requests_sent, responses_seen, outliers_seen);
      $display("registers swept through window 0 to 65535, multiplier 0 to 255, step 0 to 65535");
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout");
      $display("tb: failure");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/wgod_pkg.sv
rtl/core/wgod_mul.sv
rtl/core/wgod_div.sv
rtl/core/wgod_dp.sv
rtl/core/wgod_ctrl.sv
rtl/core/weighted_gaussian_outlier_detector.sv
tb/weighted_gaussian_outlier_detector_test.sv
